### rtl/meh_pkg.sv
package meh_pkg;

    localparam int MAX_MULTIPLICITY = 15;
    localparam int NUM_BINS         = 71;
    localparam int COUNT_BITS       = 32;

    localparam int ROM_EDGES   = 71;
    localparam int ROWS        = MAX_MULTIPLICITY + 1;
    localparam int DEPTH       = ROWS * NUM_BINS;
    localparam int ADDR_BITS   = $clog2(DEPTH);

    localparam int OPC_BITS    = 2;
    localparam int MULT_BITS   = 5;
    localparam int ENERGY_BITS = 16;
    localparam int BIN_BITS    = 7;
    localparam int STAT_BITS   = 2;
    localparam int CNT_OUT_BITS = 32;

    localparam int IN_WORD_BITS  = 32;
    localparam int OUT_WORD_BITS = 48;

    localparam logic [OPC_BITS-1:0] OP_RECORD = 2'd0;
    localparam logic [OPC_BITS-1:0] OP_READ   = 2'd1;
    localparam logic [OPC_BITS-1:0] OP_CLEAR  = 2'd2;

    localparam logic [STAT_BITS-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_ENERGY = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_MULT   = 2'd2;
    localparam logic [STAT_BITS-1:0] ST_BIN    = 2'd3;

    typedef logic [COUNT_BITS-1:0] t_count;

    typedef struct packed {
        logic [STAT_BITS-1:0] status;
        logic [BIN_BITS-1:0]  bin;
    } t_lookup;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_READ,
        S_UPDATE
    } t_state;

    // upper bin edges in keV
    localparam logic [ENERGY_BITS-1:0] EDGE_ROM [ROM_EDGES] = '{
        16'd15,    16'd35,    16'd55,    16'd75,    16'd95,
        16'd115,   16'd135,   16'd165,   16'd195,   16'd225,
        16'd255,   16'd305,   16'd355,   16'd405,   16'd455,
        16'd505,   16'd555,   16'd605,   16'd655,   16'd705,
        16'd755,   16'd805,   16'd855,   16'd905,   16'd955,
        16'd1050,  16'd1150,  16'd1250,  16'd1350,  16'd1450,
        16'd1550,  16'd1650,  16'd1750,  16'd1850,  16'd1950,
        16'd2150,  16'd2350,  16'd2550,  16'd2750,  16'd2950,
        16'd3250,  16'd3550,  16'd3850,  16'd4150,  16'd4450,
        16'd4750,  16'd5050,  16'd5550,  16'd6050,  16'd6550,
        16'd7050,  16'd7550,  16'd8050,  16'd8550,  16'd9050,
        16'd9550,  16'd10050, 16'd10550, 16'd11050, 16'd11550,
        16'd12050, 16'd12550, 16'd13050, 16'd13550, 16'd14050,
        16'd14600, 16'd15900, 16'd16900, 16'd17900, 16'd19100,
        16'd20000
    };

    function automatic logic [ENERGY_BITS-1:0] upper_edge(input int b);
        logic [ENERGY_BITS-1:0] e;
        if (b < ROM_EDGES) begin
            e = EDGE_ROM[b];
        end else begin
            e = EDGE_ROM[ROM_EDGES-1];
        end
        return e;
    endfunction

endpackage

### rtl/meh_count_ram.sv
module meh_count_ram #(
    parameter int DEPTH     = 1136,
    parameter int WIDTH     = 32,
    parameter int ADDR_BITS = 11
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/meh_bin_lookup.sv
module meh_bin_lookup (
    input  logic [meh_pkg::OPC_BITS-1:0]    i_opcode,
    input  logic [meh_pkg::MULT_BITS-1:0]   i_multiplicity,
    input  logic [meh_pkg::ENERGY_BITS-1:0] i_energy_kev,
    input  logic [meh_pkg::BIN_BITS-1:0]    i_read_bin,
    output meh_pkg::t_lookup                o_result
);

    logic [meh_pkg::NUM_BINS-1:0] w_below;
    logic [meh_pkg::NUM_BINS-1:0] w_hit;
    logic [meh_pkg::BIN_BITS-1:0] w_bin;
    logic                         w_mult_bad;
    logic                         w_bin_bad;

    // edges rise, so w_below is a thermometer code
    always_comb begin
        for (int b = 0; b < meh_pkg::NUM_BINS; b++) begin
            w_below[b] = i_energy_kev < meh_pkg::upper_edge(b);
        end
    end

    always_comb begin
        w_hit[0] = w_below[0];
        for (int b = 1; b < meh_pkg::NUM_BINS; b++) begin
            w_hit[b] = w_below[b] & ~w_below[b-1];
        end
    end

    always_comb begin
        w_bin = '0;
        for (int b = 0; b < meh_pkg::NUM_BINS; b++) begin
            w_bin = w_bin | (w_hit[b] ? meh_pkg::BIN_BITS'(b) : '0);
        end
    end

    assign w_mult_bad = {1'b0, i_multiplicity} > (meh_pkg::MULT_BITS+1)'(meh_pkg::MAX_MULTIPLICITY);
    assign w_bin_bad  = {1'b0, i_read_bin} >= (meh_pkg::BIN_BITS+1)'(meh_pkg::NUM_BINS);

    always_comb begin
        o_result.status = meh_pkg::ST_OK;
        o_result.bin    = '0;
        priority if (w_mult_bad) begin
            o_result.status = meh_pkg::ST_MULT;
        end else if (i_opcode == meh_pkg::OP_RECORD) begin
            if (w_below[meh_pkg::NUM_BINS-1]) begin
                o_result.bin = w_bin;
            end else begin
                o_result.status = meh_pkg::ST_ENERGY;
            end
        end else if (w_bin_bad) begin
            o_result.status = meh_pkg::ST_BIN;
        end else begin
            o_result.bin = i_read_bin;
        end
    end

endmodule

### rtl/multiplicity_energy_histogram_unit.sv
// multiplicity by energy histogram, one counter per multiplicity row and energy bin
//
// input stream (s_axis): one word per command; record files an energy into the
// first bin whose upper edge lies above it and bumps that counter (saturating),
// read returns one counter, clear zeroes one counter
// output stream (m_axis): exactly one word per command with status, bin, count
// and the saturated flag; error words carry zero in all other fields
//
// each command passes accept, edge compare, counter memory read and
// read-modify-write, in that order; the counter memory has one write and one read
// port with a registered read, and the result word is registered at the last step.
// the output register holds a finished word while the next command is taken;
// if the receiver stalls, the update stage waits until that register is free
//
// after reset the memory is swept to zero, one counter per cycle over all 1136
// counters, during which s_axis_tready stays low
module multiplicity_energy_histogram_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // opcode[1:0], multiplicity[6:2], energy_kev[22:7], read_bin[29:23]
    input  logic [31:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // status[1:0], bin_index[8:2], count_value[40:9], saturated[41]
    output logic [47:0] o_m_axis_tdata
);

    meh_pkg::t_state r_state;
    meh_pkg::t_state n_state;

    logic [meh_pkg::ADDR_BITS-1:0]   r_clr_addr;
    logic [meh_pkg::OPC_BITS-1:0]    r_opcode;
    logic [meh_pkg::MULT_BITS-1:0]   r_mult;
    logic [meh_pkg::ENERGY_BITS-1:0] r_energy;
    logic [meh_pkg::BIN_BITS-1:0]    r_rbin;
    meh_pkg::t_lookup                r_lookup;
    logic                            r_out_valid;
    logic [meh_pkg::OUT_WORD_BITS-1:0] r_out_data;

    meh_pkg::t_lookup                w_lookup;
    logic                            w_accept;
    logic                            w_out_free;
    logic                            w_clear_last;
    logic                            w_s_ready;
    logic                            w_grab;
    logic                            w_do_lookup;
    logic                            w_re;
    logic                            w_load_out;
    logic                            w_upd_we;
    logic                            w_we;
    logic [meh_pkg::ADDR_BITS-1:0]   w_cnt_addr;
    logic [meh_pkg::ADDR_BITS-1:0]   w_waddr;
    meh_pkg::t_count                 w_wdata;
    meh_pkg::t_count                 w_rdata;
    meh_pkg::t_count                 w_new;
    logic                            w_ok;
    logic                            w_sat;

    assign w_accept     = i_s_axis_tvalid & w_s_ready;
    assign w_out_free   = ~r_out_valid | i_m_axis_tready;
    assign w_clear_last = r_clr_addr == meh_pkg::ADDR_BITS'(meh_pkg::DEPTH - 1);
    assign w_ok         = r_lookup.status == meh_pkg::ST_OK;

    meh_bin_lookup u_lookup (
        .i_opcode       (r_opcode),
        .i_multiplicity (r_mult),
        .i_energy_kev   (r_energy),
        .i_read_bin     (r_rbin),
        .o_result       (w_lookup)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            meh_pkg::S_CLEAR: begin
                if (w_clear_last) begin
                    n_state = meh_pkg::S_IDLE;
                end
            end
            meh_pkg::S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = meh_pkg::S_LOOKUP;
                end
            end
            meh_pkg::S_LOOKUP: n_state = meh_pkg::S_READ;
            meh_pkg::S_READ:   n_state = meh_pkg::S_UPDATE;
            meh_pkg::S_UPDATE: begin
                if (w_out_free) begin
                    n_state = meh_pkg::S_IDLE;
                end
            end
            default: n_state = meh_pkg::S_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        w_s_ready   = 1'b0;
        w_do_lookup = 1'b0;
        w_re        = 1'b0;
        w_load_out  = 1'b0;
        unique case (r_state)
            meh_pkg::S_CLEAR:  w_s_ready = 1'b0;
            meh_pkg::S_IDLE:   w_s_ready = 1'b1;
            meh_pkg::S_LOOKUP: w_do_lookup = 1'b1;
            meh_pkg::S_READ:   w_re = w_ok;
            meh_pkg::S_UPDATE: w_load_out = w_out_free;
            default:           w_s_ready = 1'b0;
        endcase
    end

    assign w_grab = w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= meh_pkg::S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == meh_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_grab) begin
            r_opcode <= i_s_axis_tdata[1:0];
            r_mult   <= i_s_axis_tdata[6:2];
            r_energy <= i_s_axis_tdata[22:7];
            r_rbin   <= i_s_axis_tdata[29:23];
        end
        if (w_do_lookup) begin
            r_lookup <= w_lookup;
        end
    end

    assign w_cnt_addr = meh_pkg::ADDR_BITS'(
        meh_pkg::ADDR_BITS'(r_mult) * meh_pkg::ADDR_BITS'(meh_pkg::NUM_BINS)
        + meh_pkg::ADDR_BITS'(r_lookup.bin));

    // read-modify-write
    always_comb begin
        w_new = w_rdata;
        if (r_opcode == meh_pkg::OP_RECORD) begin
            if (w_rdata != '1) begin
                w_new = w_rdata + 1'b1;
            end
        end else if (r_opcode == meh_pkg::OP_CLEAR) begin
            w_new = '0;
        end
    end

    assign w_sat    = w_new == '1;
    assign w_upd_we = w_load_out & w_ok
                      & (r_opcode == meh_pkg::OP_RECORD || r_opcode == meh_pkg::OP_CLEAR);
    assign w_we     = (r_state == meh_pkg::S_CLEAR) | w_upd_we;
    assign w_waddr  = (r_state == meh_pkg::S_CLEAR) ? r_clr_addr : w_cnt_addr;
    assign w_wdata  = (r_state == meh_pkg::S_CLEAR) ? '0 : w_new;

    meh_count_ram #(
        .DEPTH     (meh_pkg::DEPTH),
        .WIDTH     (meh_pkg::COUNT_BITS),
        .ADDR_BITS (meh_pkg::ADDR_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_cnt_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            if (w_ok) begin
                r_out_data <= {6'd0, w_sat, meh_pkg::CNT_OUT_BITS'(w_new),
                               r_lookup.bin, r_lookup.status};
            end else begin
                r_out_data <= {6'd0, 1'b0, meh_pkg::CNT_OUT_BITS'(0),
                               meh_pkg::BIN_BITS'(0), r_lookup.status};
            end
        end
    end

    assign o_s_axis_tready = w_s_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_err_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[1:0] != meh_pkg::ST_OK)
        |-> (r_out_data[47:2] == '0))
        else $error("error word carries nonzero fields");

    a_write_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && r_state != meh_pkg::S_CLEAR) |-> (w_ok && r_state == meh_pkg::S_UPDATE))
        else $error("counter written for a failed command");

    a_accept_to_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == meh_pkg::S_LOOKUP))
        else $error("accepted word did not enter lookup");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == meh_pkg::S_UPDATE && r_out_valid && !i_m_axis_tready)
        |=> (r_state == meh_pkg::S_UPDATE && r_out_valid))
        else $error("update overran a waiting output word");
`endif

endmodule
